[hdl/mtts_pkg.sv]
package mtts_pkg;

  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotBits   = 4;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned IdBits     = 32;
  localparam int unsigned CountBits  = 5;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  localparam logic [1:0] CmdAdd     = 2'd0;
  localparam logic [1:0] CmdCancel  = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;
  localparam logic [1:0] CmdIgnored = 2'd3;

  localparam logic [2:0] KindAdded  = 3'd0;
  localparam logic [2:0] KindFull   = 3'd1;
  localparam logic [2:0] KindCancel = 3'd2;
  localparam logic [2:0] KindFired  = 3'd3;
  localparam logic [2:0] KindDone   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_add;
    logic do_cancel;
    logic do_advance;   // elapsed += delta (saturating), take a pending snapshot
    logic do_scan_clr;  // start a minimum search
    logic do_scan;      // visit one slot of the search
    logic do_fire;      // fire the picked slot
    logic do_free;      // free all cancelled slots
    logic [SlotBits-1:0] scan_idx;
  } mtts_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic has_free;
    logic found;
    logic pick_valid;
    logic [IdBits-1:0] pick_id;
    logic [IdBits-1:0] next_id;
    logic [CountBits-1:0] used_cnt;
    logic [CountBits-1:0] freed_cnt;
  } mtts_stat_t;

  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] a,
                                                  input logic [IdBits-1:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {{(TimeBits-IdBits+1){1'b0}}, b};
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction

endpackage

[hdl/mtts_datapath.sv]
module mtts_datapath
  import mtts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdBits-1:0]   cfg_wdata_i,
  input  mtts_cmd_t           cmd_i,
  input  logic [IdBits-1:0]   interval_i,
  input  logic                repeat_i,
  input  logic [IdBits-1:0]   cancel_id_i,
  input  logic [IdBits-1:0]   delta_i,
  output mtts_stat_t          stat_o
);

  logic [TimerSlots-1:0] used_q, canc_q, pend_q;
  logic [TimerSlots-1:0] rep_q;
  logic [IdBits-1:0]     ident_q [TimerSlots];
  logic [IdBits-1:0]     intv_q  [TimerSlots];
  logic [TimeBits-1:0]   due_q   [TimerSlots];
  logic [TimeBits-1:0]   elapsed_q;
  logic [IdBits-1:0]     next_q;
  logic                  pick_v_q;
  logic [SlotBits-1:0]   pick_q;
  logic [IdBits-1:0]     pick_id_q;

  logic [SlotBits-1:0]   free_idx;
  logic                  has_free;
  logic [TimerSlots-1:0] match;
  logic [TimeBits-1:0]   elapsed_n;
  logic [IdBits-1:0]     intv_n;

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = TimerSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        has_free = 1'b1;
        free_idx = SlotBits'(i);
      end
    end
    for (int i = 0; i < TimerSlots; i++) begin
      match[i] = used_q[i] && (ident_q[i] == cancel_id_i);
    end
    elapsed_n = sat_add(elapsed_q, delta_i);
    intv_n    = (interval_i == '0) ? IdBits'(1) : interval_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      canc_q    <= '0;
      pend_q    <= '0;
      elapsed_q <= '0;
      next_q    <= IdBits'(1);
      pick_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        next_q <= cfg_wdata_i;
      end
      if (cmd_i.do_add && has_free) begin
        used_q[free_idx] <= 1'b1;
        canc_q[free_idx] <= 1'b0;
        next_q           <= next_q + IdBits'(1);
      end
      if (cmd_i.do_cancel) begin
        canc_q <= canc_q | match;
      end
      if (cmd_i.do_advance) begin
        elapsed_q <= elapsed_n;
        for (int i = 0; i < TimerSlots; i++) begin
          pend_q[i] <= used_q[i] && !canc_q[i] && (elapsed_n >= due_q[i]);
        end
      end
      if (cmd_i.do_scan_clr) begin
        pick_v_q <= 1'b0;
      end
      if (cmd_i.do_scan && pend_q[cmd_i.scan_idx] &&
          (!pick_v_q || ident_q[cmd_i.scan_idx] < pick_id_q)) begin
        pick_v_q <= 1'b1;
      end
      if (cmd_i.do_fire) begin
        pend_q[pick_q] <= 1'b0;
        if (!rep_q[pick_q]) begin
          canc_q[pick_q] <= 1'b1;
        end
      end
      if (cmd_i.do_free) begin
        used_q <= used_q & ~canc_q;
        canc_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add && has_free) begin
      rep_q[free_idx]   <= repeat_i;
      ident_q[free_idx] <= next_q;
      intv_q[free_idx]  <= intv_n;
      due_q[free_idx]   <= sat_add(elapsed_q, intv_n);
    end
    if (cmd_i.do_scan && pend_q[cmd_i.scan_idx] &&
        (!pick_v_q || ident_q[cmd_i.scan_idx] < pick_id_q)) begin
      pick_q    <= cmd_i.scan_idx;
      pick_id_q <= ident_q[cmd_i.scan_idx];
    end
    if (cmd_i.do_fire && rep_q[pick_q]) begin
      due_q[pick_q] <= sat_add(elapsed_q, intv_q[pick_q]);
    end
  end

  always_comb begin
    stat_o.has_free   = has_free;
    stat_o.found      = |match;
    stat_o.pick_valid = pick_v_q;
    stat_o.pick_id    = pick_id_q;
    stat_o.next_id    = next_q;
    stat_o.used_cnt   = CountBits'($countones(used_q));
    stat_o.freed_cnt  = CountBits'($countones(used_q & ~canc_q));
  end

endmodule

[hdl/mtts_ctrl.sv]
module mtts_ctrl
  import mtts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  output mtts_cmd_t           cmd_o,
  input  mtts_stat_t          stat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          kind_o,
  output logic [IdBits-1:0]   timer_id_o,
  output logic                found_o,
  output logic [CountBits-1:0] count_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    StIdle, StAdvance, StScan, StDecide, StWaitFire, StWaitDone
  } state_e;

  state_e              state_q;
  logic [SlotBits-1:0] idx_q;
  logic                ov_q;
  logic [2:0]          kind_q;
  logic [IdBits-1:0]   id_q;
  logic                found_q;
  logic [CountBits-1:0] cnt_q;
  logic                last_q;

  logic accept;
  logic out_free;
  logic ov_set;

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // A new result word is loaded after add or cancel and at every decision step.
  assign ov_set = (accept && (command_i inside {CmdAdd, CmdCancel})) ||
                  ((state_q == StDecide) && out_free);

  always_comb begin
    cmd_o = '0;
    cmd_o.scan_idx = idx_q;
    case (state_q)
      StIdle: begin
        cmd_o.do_add     = accept && (command_i == CmdAdd);
        cmd_o.do_cancel  = accept && (command_i == CmdCancel);
        // The delta is only on the bus while the word is accepted.
        cmd_o.do_advance = accept && (command_i == CmdTick);
      end
      StAdvance: begin
        cmd_o.do_scan_clr = 1'b1;
      end
      StScan: cmd_o.do_scan = 1'b1;
      StDecide: begin
        if (out_free) begin
          cmd_o.do_fire = stat_i.pick_valid;
          cmd_o.do_free = !stat_i.pick_valid;
          cmd_o.do_scan_clr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      kind_q  <= KindDone;
      id_q    <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      if (ov_set) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (command_i)
              CmdAdd: begin
                kind_q  <= stat_i.has_free ? KindAdded : KindFull;
                id_q    <= stat_i.has_free ? stat_i.next_id : '0;
                found_q <= 1'b0;
                cnt_q   <= stat_i.used_cnt + CountBits'(stat_i.has_free);
                last_q  <= 1'b1;
              end
              CmdCancel: begin
                kind_q  <= KindCancel;
                id_q    <= '0;
                found_q <= stat_i.found;
                cnt_q   <= stat_i.used_cnt;
                last_q  <= 1'b1;
              end
              CmdTick: state_q <= StAdvance;
              default: ;
            endcase
          end
        end
        StAdvance: begin
          idx_q   <= '0;
          state_q <= StScan;
        end
        StScan: begin
          idx_q <= idx_q + SlotBits'(1);
          if (idx_q == SlotBits'(TimerSlots - 1)) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (out_free) begin
            found_q <= 1'b0;
            if (stat_i.pick_valid) begin
              kind_q  <= KindFired;
              id_q    <= stat_i.pick_id;
              cnt_q   <= stat_i.used_cnt;
              last_q  <= 1'b0;
              idx_q   <= '0;
              state_q <= StScan;
            end else begin
              kind_q  <= KindDone;
              id_q    <= '0;
              cnt_q   <= stat_i.freed_cnt;
              last_q  <= 1'b1;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign timer_id_o  = id_q;
  assign found_o     = found_q;
  assign count_o     = cnt_q;
  assign last_o      = last_q;

endmodule

[hdl/multi_timer_table_scheduler.sv]
// Add and cancel: the result word is registered and valid in the cycle after accept.
// Tick: time advances at the accept edge, a setup step follows, then each fired
// timer takes a 16-slot minimum search plus issue, and the done word takes one more
// search; a result word waiting on m_axis_tready stalls the sequence. One input
// word at a time.
// Reset (rst_ni low, asynchronous) empties the table, clears time, next id is 1.
module multi_timer_table_scheduler
  import mtts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], interval_ms[33:2], repeat_flag[34], cancel_id[66:35],
  // delta_ms[98:67], zero fill to 104 bits
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[2:0], timer_id[34:3], found[35], active_count[40:36], zero fill
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  mtts_cmd_t  cmd;
  mtts_stat_t stat;
  logic [2:0]           kind;
  logic [IdBits-1:0]    tid;
  logic                 fnd;
  logic [CountBits-1:0] cnt;

  mtts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .interval_i  (s_axis_tdata[33:2]),
    .repeat_i    (s_axis_tdata[34]),
    .cancel_id_i (s_axis_tdata[66:35]),
    .delta_i     (s_axis_tdata[98:67]),
    .stat_o      (stat)
  );

  mtts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tdata[1:0]),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (kind),
    .timer_id_o  (tid),
    .found_o     (fnd),
    .count_o     (cnt),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, cnt, fnd, tid, kind};

endmodule
